// ----- hw/rtl/owf_pkg.sv -----
// shared types and constants for the overwrite fifo with purge
`timescale 1ns / 1ps

package owf_pkg;

  localparam int HANDLE_W      = 32;
  localparam int OCC_W         = 5;
  localparam int DEPTH_DEFAULT = 32;
  localparam int REQ_W         = 2;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PURGE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PURGE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic push;          // write handle at head, advance head (and tail when full)
    logic pop_read;      // read slot at tail
    logic pop_take;      // load read data into the result, advance tail
    logic purge_start;   // latch key, read and write pointers to tail
    logic purge_issue;   // read slot at purge read pointer
    logic purge_finish;  // head to the final write pointer
    logic load_zero;     // load an empty result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic purge_more;    // purge read pointer has not reached head
  } status_t;

endpackage

// ----- hw/rtl/owf_datapath.sv -----
// ring storage, pointers, purge walk and result registers
`timescale 1ns / 1ps

module owf_datapath #(
  parameter int DEPTH = owf_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  owf_pkg::cmd_t                 cmd,
  output owf_pkg::status_t              status,
  input  logic [owf_pkg::HANDLE_W-1:0]  in_handle,
  output logic [owf_pkg::HANDLE_W-1:0]  out_handle,
  output logic                          out_present,
  output logic [owf_pkg::OCC_W-1:0]     occupancy
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [owf_pkg::HANDLE_W-1:0] mem [DEPTH];
  logic [owf_pkg::HANDLE_W-1:0] rdata;
  logic [owf_pkg::HANDLE_W-1:0] key;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic             pend;

  logic [PTR_W-1:0] head_adv;
  logic [PTR_W-1:0] tail_adv;
  logic [PTR_W-1:0] rd_adv;
  logic [PTR_W-1:0] wr_adv;
  logic [PTR_W-1:0] wr_ptr_next;
  logic             keep;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [owf_pkg::HANDLE_W-1:0] wdata;
  logic [PTR_W:0]   diff;
  logic [31:0]      occ_wide;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign head_adv = advance(head);
  assign tail_adv = advance(tail);
  assign rd_adv   = advance(rd_ptr);
  assign wr_adv   = advance(wr_ptr);

  // entry read last cycle survives unless it matches the purge key
  assign keep        = pend && (rdata != key);
  assign wr_ptr_next = keep ? wr_adv : wr_ptr;

  assign rd_en   = cmd.pop_read || cmd.purge_issue;
  assign rd_addr = cmd.pop_read ? tail : rd_ptr;
  assign we      = cmd.push || keep;
  assign waddr   = cmd.push ? head : wr_ptr;
  assign wdata   = cmd.push ? in_handle : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.purge_issue;
      if (cmd.push) begin
        head <= head_adv;
        if (head_adv == tail) begin
          tail <= tail_adv;
        end
      end
      if (cmd.pop_take) begin
        tail <= tail_adv;
      end
      if (cmd.purge_finish) begin
        head <= wr_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.purge_start) begin
      key    <= in_handle;
      rd_ptr <= tail;
      wr_ptr <= tail;
    end else begin
      if (cmd.purge_issue) begin
        rd_ptr <= rd_adv;
      end
      wr_ptr <= wr_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_take) begin
      out_handle  <= rdata;
      out_present <= 1'b1;
    end else if (cmd.load_zero) begin
      out_handle  <= '0;
      out_present <= 1'b0;
    end
  end

  always_comb begin
    if (head >= tail) begin
      diff = {1'b0, head} - {1'b0, tail};
    end else begin
      diff = {1'b0, head} + (PTR_W + 1)'(DEPTH) - {1'b0, tail};
    end
  end

  assign occ_wide  = 32'(diff);
  assign occupancy = occ_wide[owf_pkg::OCC_W-1:0];

  assign status.empty      = (head == tail);
  assign status.purge_more = (rd_ptr != head);

endmodule

// ----- hw/rtl/owf_ctrl.sv -----
// request sequencer and result handshake for the overwrite fifo
`timescale 1ns / 1ps

module owf_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [owf_pkg::REQ_W-1:0]  req_type,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output owf_pkg::cmd_t              cmd,
  input  owf_pkg::status_t           status
);

  owf_pkg::state_t state;
  owf_pkg::state_t state_next;
  owf_pkg::req_t   req;
  logic            accept;
  logic            load;
  logic            out_valid;
  logic            out_valid_next;

  assign req      = owf_pkg::req_t'(req_type);
  assign s_tready = (state == owf_pkg::ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      owf_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            owf_pkg::REQ_POP: begin
              if (!status.empty) begin
                state_next = owf_pkg::ST_POP;
              end
            end
            owf_pkg::REQ_PURGE: begin
              if (!status.empty) begin
                state_next = owf_pkg::ST_PURGE;
              end
            end
            default: state_next = owf_pkg::ST_IDLE;
          endcase
        end
      end
      owf_pkg::ST_POP: state_next = owf_pkg::ST_IDLE;
      owf_pkg::ST_PURGE: begin
        if (!status.purge_more) begin
          state_next = owf_pkg::ST_IDLE;
        end
      end
      default: state_next = owf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      owf_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            owf_pkg::REQ_PUSH: begin
              cmd.push      = 1'b1;
              cmd.load_zero = 1'b1;
            end
            owf_pkg::REQ_POP: begin
              cmd.pop_read  = !status.empty;
              cmd.load_zero = status.empty;
            end
            owf_pkg::REQ_PURGE: begin
              cmd.purge_start = !status.empty;
              cmd.load_zero   = status.empty;
            end
            default: cmd.load_zero = 1'b1;
          endcase
        end
      end
      owf_pkg::ST_POP: cmd.pop_take = 1'b1;
      owf_pkg::ST_PURGE: begin
        cmd.purge_issue  = status.purge_more;
        cmd.purge_finish = !status.purge_more;
        cmd.load_zero    = !status.purge_more;
      end
      default: cmd = '0;
    endcase
  end

  assign load           = cmd.load_zero || cmd.pop_take;
  assign out_valid_next = load ? 1'b1 : (out_valid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= owf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  // a result is never loaded over one that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || m_tready))
    else $error("result loaded over a pending transfer");

  // the output register is free while a pop waits on the memory read
  a_pop_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == owf_pkg::ST_POP) |-> !out_valid)
    else $error("output busy during pop");

  // a purge walk only starts on a queue that holds something
  a_purge_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == owf_pkg::ST_PURGE && $past(state) == owf_pkg::ST_IDLE) |-> status.purge_more)
    else $error("purge walk started on empty queue");

  // intake stays closed for the whole purge walk
  a_purge_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == owf_pkg::ST_PURGE) |-> !s_tready)
    else $error("intake open during purge");
`endif

endmodule

// ----- hw/rtl/overwrite_fifo_with_purge_core.sv -----
// top level of the overwrite fifo with purge
`timescale 1ns / 1ps

// Ring FIFO of 32-bit handles with DEPTH slots, holding at most DEPTH-1. Each
// request is one transfer on the slave side (tuser selects push, pop or purge)
// and returns one transfer on the master side with the popped handle, a present
// flag and the occupancy after the request. A push into a full ring drops the
// oldest handle. Push, pop of an empty ring, purge of an empty ring and unknown
// requests finish in the accepting cycle; a pop also passes through ST_POP because
// the slot memory has a registered read; a purge of n held handles has the
// accepting cycle, one slot read and at most one slot write per cycle through the
// single memory port pair, and a closing step for the last write, with intake
// closed meanwhile. A new request is taken while the last result waits only if that
// result is transferred in the same cycle.
module overwrite_fifo_with_purge_core #(
  parameter int DEPTH = owf_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [owf_pkg::HANDLE_W-1:0]     s_tdata,   // [31:0] item_handle
  input  logic [owf_pkg::REQ_W-1:0]        s_tuser,   // [1:0] req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [owf_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] popped_handle, [36:32] occupancy
  output logic                             m_tuser    // [0] popped_present
);

  owf_pkg::cmd_t    cmd;
  owf_pkg::status_t status;

  logic [owf_pkg::HANDLE_W-1:0] out_handle;
  logic [owf_pkg::OCC_W-1:0]    occupancy;

  owf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  owf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_handle   (s_tdata),
    .out_handle  (out_handle),
    .out_present (m_tuser),
    .occupancy   (occupancy)
  );

  assign m_tdata = {{(owf_pkg::OUT_DATA_W - owf_pkg::HANDLE_W - owf_pkg::OCC_W){1'b0}},
                    occupancy, out_handle};

endmodule

// ----- sim/tb_overwrite_fifo_with_purge_core.sv -----
// self-checking testbench for the overwrite fifo with purge core
`timescale 1ns / 1ps

module tb_overwrite_fifo_with_purge_core;

  localparam int DEPTH = owf_pkg::DEPTH_DEFAULT;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [owf_pkg::REQ_W-1:0] REQ_OTHER = 2'd3;  // no such request, block must ignore it
  localparam int MAX_PRINTS = 20;

  typedef struct packed {
    logic [owf_pkg::HANDLE_W-1:0] handle;
    logic                         present;
    logic [owf_pkg::OCC_W-1:0]    occ;
  } owf_reply_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [owf_pkg::HANDLE_W-1:0]   s_tdata;   // [31:0] item_handle
  logic [owf_pkg::REQ_W-1:0]      s_tuser;   // [1:0] req_type
  logic                           m_tvalid;
  logic                           m_tready;
  logic [owf_pkg::OUT_DATA_W-1:0] m_tdata;   // [31:0] popped_handle, [36:32] occupancy
  logic                           m_tuser;   // [0] popped_present

  overwrite_fifo_with_purge_core #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // own copy of the ring
  logic [owf_pkg::HANDLE_W-1:0] ring [DEPTH];
  logic [PTR_W-1:0]             ring_head = '0;
  logic [PTR_W-1:0]             ring_tail = '0;

  owf_reply_t expected_replies [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int n_push    = 0;
  int n_pop     = 0;
  int n_purge   = 0;
  int n_other   = 0;
  int n_found   = 0;
  int n_dropped = 0;
  int n_removed = 0;

  logic [owf_pkg::HANDLE_W-1:0] key_pool [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d replies outstanding", expected_replies.size());
    $display("tb_overwrite_fifo_with_purge_core: FAIL");
    $finish;
  end

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [owf_pkg::OCC_W-1:0] held();
    return owf_pkg::OCC_W'((int'(ring_head) + DEPTH - int'(ring_tail)) % DEPTH);
  endfunction

  // advance the ring copy by one request and return the reply it should give
  function automatic owf_reply_t predict_fifo_reply(input logic [owf_pkg::REQ_W-1:0] req,
                                                    input logic [owf_pkg::HANDLE_W-1:0] h);
    owf_reply_t                   r;
    logic [PTR_W-1:0]             rd;
    logic [PTR_W-1:0]             wr;
    logic [owf_pkg::HANDLE_W-1:0] v;
    r = '0;
    case (req)
      owf_pkg::REQ_PUSH: begin
        n_push++;
        ring[ring_head] = h;
        ring_head = bump(ring_head);
        if (ring_head == ring_tail) begin
          ring_tail = bump(ring_tail);
          n_dropped++;
        end
      end
      owf_pkg::REQ_POP: begin
        n_pop++;
        if (ring_head != ring_tail) begin
          r.handle  = ring[ring_tail];
          r.present = 1'b1;
          ring_tail = bump(ring_tail);
          n_found++;
        end
      end
      owf_pkg::REQ_PURGE: begin
        n_purge++;
        if (ring_head != ring_tail) begin
          rd = ring_tail;
          wr = ring_tail;
          do begin
            v  = ring[rd];
            rd = bump(rd);
            if (v != h) begin
              ring[wr] = v;
              wr = bump(wr);
            end else begin
              n_removed++;
            end
          end while (rd != ring_head);
          ring_head = wr;
        end
      end
      default: n_other++;
    endcase
    r.occ = held();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [owf_pkg::HANDLE_W-1:0] got,
                                 input logic [owf_pkg::HANDLE_W-1:0] want);
    if (n_errors < MAX_PRINTS)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // predict on every request transfer, check every reply transfer
  always @(posedge clk) begin
    owf_reply_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_replies.push_back(predict_fifo_reply(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding",
                          m_tdata[owf_pkg::HANDLE_W-1:0], '0);
        end else begin
          want = expected_replies.pop_front();
          n_checked++;
          if (m_tdata[owf_pkg::HANDLE_W-1:0] !== want.handle)
            report_mismatch("popped_handle", m_tdata[owf_pkg::HANDLE_W-1:0], want.handle);
          if (m_tuser !== want.present)
            report_mismatch("popped_present", owf_pkg::HANDLE_W'(m_tuser),
                            owf_pkg::HANDLE_W'(want.present));
          if (m_tdata[owf_pkg::HANDLE_W+owf_pkg::OCC_W-1:owf_pkg::HANDLE_W] !== want.occ)
            report_mismatch("occupancy",
              owf_pkg::HANDLE_W'(m_tdata[owf_pkg::HANDLE_W+owf_pkg::OCC_W-1:owf_pkg::HANDLE_W]),
              owf_pkg::HANDLE_W'(want.occ));
          if (m_tdata[owf_pkg::OUT_DATA_W-1:owf_pkg::HANDLE_W+owf_pkg::OCC_W] !== '0)
            report_mismatch("tdata padding",
              owf_pkg::HANDLE_W'(m_tdata[owf_pkg::OUT_DATA_W-1:owf_pkg::HANDLE_W+owf_pkg::OCC_W]),
              '0);
        end
      end
    end
  end

  task automatic send_req(input logic [owf_pkg::REQ_W-1:0] req,
                          input logic [owf_pkg::HANDLE_W-1:0] h);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= h;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic test_empty_requests();
    send_req(owf_pkg::REQ_POP, 32'hFFFF_FFFF);
    send_req(owf_pkg::REQ_PURGE, 32'h0000_0000);
    send_req(REQ_OTHER, 32'hFFFF_FFFF);
  endtask

  task automatic test_push_pop_extremes();
    send_req(owf_pkg::REQ_PUSH, 32'h0000_0000);
    send_req(owf_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_req(owf_pkg::REQ_PUSH, 32'h5555_5555);
    send_req(owf_pkg::REQ_PUSH, 32'hAAAA_AAAA);
    repeat (4) send_req(owf_pkg::REQ_POP, 32'h1234_5678);
    // one more than held: empty again
    send_req(owf_pkg::REQ_POP, 32'h0);
  endtask

  task automatic test_purge_cases();
    send_req(owf_pkg::REQ_PUSH, 32'h0000_00A1);
    send_req(owf_pkg::REQ_PUSH, 32'h0000_00B2);
    send_req(owf_pkg::REQ_PUSH, 32'h0000_00A1);
    send_req(owf_pkg::REQ_PUSH, 32'h0000_00C3);
    send_req(owf_pkg::REQ_PUSH, 32'h0000_00A1);
    send_req(owf_pkg::REQ_PURGE, 32'h0000_00A1);
    // key not held, order stays
    send_req(owf_pkg::REQ_PURGE, 32'h0000_00D4);
    send_req(owf_pkg::REQ_POP, 32'h0);
    send_req(owf_pkg::REQ_POP, 32'h0);
    // purge that removes everything
    send_req(owf_pkg::REQ_PUSH, 32'h8000_0001);
    send_req(owf_pkg::REQ_PUSH, 32'h8000_0001);
    send_req(owf_pkg::REQ_PURGE, 32'h8000_0001);
  endtask

  function automatic logic [owf_pkg::HANDLE_W-1:0] pick_handle(input int pool_pct);
    if ($urandom_range(99) < pool_pct)
      return key_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic refresh_pool();
    int i;
    for (i = 0; i < 4; i++) key_pool[i] = $urandom;
    if ($urandom_range(3) == 0) key_pool[0] = '0;
    if ($urandom_range(3) == 0) key_pool[1] = '1;
  endtask

  // bursts of pushes, drains, purges and long fills that can run past full, with some noise
  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int k;
    int burst;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(7) == 0) refresh_pool();
      k = $urandom_range(99);
      if (k < 35) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_req(owf_pkg::REQ_PUSH, pick_handle(70));
      end else if (k < 58) begin
        burst = $urandom_range(1, 10);
        repeat (burst) send_req(owf_pkg::REQ_POP, $urandom);
      end else if (k < 74) begin
        send_req(owf_pkg::REQ_PURGE, pick_handle(80));
      end else if (k < 80) begin
        burst = $urandom_range(30, 40);
        repeat (burst) send_req(owf_pkg::REQ_PUSH, pick_handle(50));
      end else if (k < 87) begin
        send_req(REQ_OTHER, $urandom);
      end else begin
        send_req(owf_pkg::REQ_W'($urandom_range(3)), pick_handle(50));
      end
    end
  endtask

  task automatic finish_run();
    int waited;
    s_tvalid <= 1'b0;
    sink_stall_pct = 0;
    waited = 0;
    while (expected_replies.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("replies never arrived",
                      owf_pkg::HANDLE_W'(expected_replies.size()), '0);
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    refresh_pool();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_requests();
    test_push_pop_extremes();
    test_purge_cases();

    test_random_traffic(210);
    src_idle_pct   = 68;
    sink_stall_pct = 0;
    test_random_traffic(210);
    src_idle_pct   = 0;
    sink_stall_pct = 68;
    test_random_traffic(210);
    src_idle_pct   = 36;
    sink_stall_pct = 36;
    test_random_traffic(210);

    finish_run();

    $display("sent %0d requests: %0d push, %0d pop, %0d purge, %0d unknown; %0d replies checked",
             n_sent, n_push, n_pop, n_purge, n_other, n_checked);
    $display("pops that found a handle %0d, oldest dropped on full %0d, purged entries %0d",
             n_found, n_dropped, n_removed);
    if (n_errors == 0) begin
      $display("tb_overwrite_fifo_with_purge_core: PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_overwrite_fifo_with_purge_core: FAIL");
    end
    $finish;
  end

endmodule
